>>> hw/rtl/bilateral_filter_gray_core_macros.svh
// Assertion helpers for the RTL core of the bilateral filter.
`ifndef BILATERAL_FILTER_GRAY_CORE_MACROS_SVH
`define BILATERAL_FILTER_GRAY_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BFG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bilateral filter check failed");

// Next-cycle implication, checked out of reset.
`define BFG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bilateral filter check failed");

`endif

>>> hw/rtl/bfg_pkg.sv
package bfg_pkg;

  localparam int MAX_RADIUS_DEF = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Accumulators are sized for the largest supported window (7 x 7).
  localparam int ACC_W = 32;
  localparam int DEN_W = 24;
  localparam int QUO_W = 8;

  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_RANGE   = 2'd1;
  localparam logic [1:0] KIND_SPATIAL = 2'd2;
  localparam logic [1:0] KIND_DRAIN   = 2'd3;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic             vld;
    logic [ACC_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

>>> hw/rtl/bilateral_filter_gray_core.sv
// Bilateral filter for 8-bit gray pixels streamed in raster order.
// Table loads are taken in the idle state; an item that releases no result returns to idle after the readiness check.
// An item that releases a result passes through one line store read per window
// tap, a 3-stage weight pipeline, then 8 division cells.
// Reset (rst_n low, synchronous) clears counters, weight tables and handshakes.
`include "bilateral_filter_gray_core_macros.svh"
module bilateral_filter_gray_core import bfg_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel[7:0], table_index[15:8], weight[31:16]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // filtered_pixel[7:0], out_row[19:8], out_col[29:20]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  localparam int ROWS     = 2 * MAX_RADIUS + 2;
  localparam int SP_DEPTH = 2 * MAX_RADIUS * MAX_RADIUS + 1;
  localparam int LS_DEPTH = ROWS * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int SW       = $clog2(ROWS);
  localparam int RW       = $clog2(MAX_HEIGHT + 1);
  localparam int CW       = $clog2(MAX_WIDTH + 1);
  localparam int RB       = $clog2(MAX_RADIUS + 1);
  localparam int TW       = $clog2(2 * MAX_RADIUS + 1);
  localparam int SPW      = $clog2(SP_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_CENTRE = 3'd2;
  localparam logic [2:0] S_CWAIT  = 3'd3;
  localparam logic [2:0] S_TAPS   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]  state_r;
  logic [1:0]  radius_r;
  logic [10:0] width_r;
  logic [12:0] height_r;

  logic [RB-1:0] eff_rad;
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;

  logic [RW-1:0] in_row_r, em_row_r;
  logic [CW-1:0] in_col_r, em_col_r;
  logic [SW-1:0] in_slot_r, em_slot_r;
  logic          in_done_r;

  logic [7:0]    ls_mem [LS_DEPTH];
  logic [7:0]    ls_q_r;
  logic [LS_AW-1:0] ls_raddr, ls_waddr;

  logic [15:0]   rt_mem [256];
  logic [255:0]  rt_vld_r;
  logic [15:0]   rt_q_r;
  logic          rt_v_r;
  logic [15:0]   sp_tab_r [SP_DEPTH];

  logic [TW-1:0] ti_r, tj_r;
  logic [7:0]    centre_r;
  logic          p1_vld_r, p1_in_r, p2_vld_r, p2_in_r, p3_vld_r;
  logic [SPW-1:0] p1_sidx_r;
  logic [7:0]    p2_n_r, p3_n_r;
  logic [15:0]   p2_s_r, p3_w_r;
  logic [ACC_W-1:0] f_acc_r;
  logic [DEN_W-1:0] k_acc_r;

  logic [7:0]    res_r;
  logic          out_vld_r, out_last_r;
  logic [31:0]   out_data_r;

  div_t dv [QUO_W+1];

  // Effective configuration.
  always_comb begin
    eff_rad = (radius_r > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(radius_r);
    if (width_r == 11'd0) begin
      eff_w = CW'(1);
    end else if (width_r > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(width_r);
    end
    if (height_r == 13'd0) begin
      eff_h = RW'(1);
    end else if (height_r > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(height_r);
    end
  end

  logic          acc_in;
  logic [1:0]    kind;
  logic          pix_take;
  assign in_tready = (state_r == S_IDLE);
  assign acc_in    = in_tvalid && in_tready;
  assign kind      = in_tuser;
  assign pix_take  = acc_in && (kind == KIND_PIXEL) && !in_done_r;

  // Readiness of the next output pixel.
  logic [RW:0] nr;
  logic [CW:0] nc;
  logic        ready_c;
  always_comb begin
    nr = (RW+1)'(em_row_r) + (RW+1)'(eff_rad);
    if (nr > (RW+1)'(eff_h - RW'(1))) nr = (RW+1)'(eff_h - RW'(1));
    nc = (CW+1)'(em_col_r) + (CW+1)'(eff_rad);
    if (nc > (CW+1)'(eff_w - CW'(1))) nc = (CW+1)'(eff_w - CW'(1));
    ready_c = in_done_r || ((RW+1)'(in_row_r) > nr) ||
              (((RW+1)'(in_row_r) == nr) && ((CW+1)'(in_col_r) > nc));
  end

  // Window tap position.
  logic [RW:0]    rsum;
  logic [CW:0]    csum;
  logic           tap_in;
  logic [CW-1:0]  tap_col;
  logic [SW+TW:0] slot_a, slot_b;
  logic [TW-1:0]  adr, adc, two_r;
  logic [2*TW:0]  sq;
  logic           tap_last;
  always_comb begin
    rsum    = (RW+1)'(em_row_r) + (RW+1)'(ti_r);
    csum    = (CW+1)'(em_col_r) + (CW+1)'(tj_r);
    tap_in  = (rsum >= (RW+1)'(eff_rad)) && (rsum - (RW+1)'(eff_rad) < (RW+1)'(eff_h)) &&
              (csum >= (CW+1)'(eff_rad)) && (csum - (CW+1)'(eff_rad) < (CW+1)'(eff_w));
    tap_col = CW'(csum - (CW+1)'(eff_rad));
    slot_a  = (SW+TW+1)'(em_slot_r) + (SW+TW+1)'(ti_r);
    if (slot_a >= (SW+TW+1)'(eff_rad)) begin
      slot_b = slot_a - (SW+TW+1)'(eff_rad);
    end else begin
      slot_b = slot_a + (SW+TW+1)'(ROWS) - (SW+TW+1)'(eff_rad);
    end
    if (slot_b >= (SW+TW+1)'(ROWS)) slot_b = slot_b - (SW+TW+1)'(ROWS);
    adr      = (ti_r >= TW'(eff_rad)) ? ti_r - TW'(eff_rad) : TW'(eff_rad) - ti_r;
    adc      = (tj_r >= TW'(eff_rad)) ? tj_r - TW'(eff_rad) : TW'(eff_rad) - tj_r;
    sq       = (2*TW+1)'(adr * adr) + (2*TW+1)'(adc * adc);
    two_r    = TW'({eff_rad, 1'b0});
    tap_last = (ti_r == two_r) && (tj_r == two_r);
    ls_waddr = LS_AW'(in_slot_r) * LS_AW'(MAX_WIDTH) + LS_AW'(in_col_r);
    if (state_r == S_CENTRE) begin
      ls_raddr = LS_AW'(em_slot_r) * LS_AW'(MAX_WIDTH) + LS_AW'(em_col_r);
    end else begin
      ls_raddr = LS_AW'(SW'(slot_b)) * LS_AW'(MAX_WIDTH) + LS_AW'(tap_col);
    end
  end

  // Line store.
  always_ff @(posedge clk) begin
    if (pix_take) ls_mem[ls_waddr] <= in_tdata[7:0];
    ls_q_r <= ls_mem[ls_raddr];
  end

  // Range weight memory; entries never loaded read as zero.
  logic [7:0] dif;
  assign dif = (ls_q_r > centre_r) ? ls_q_r - centre_r : centre_r - ls_q_r;
  always_ff @(posedge clk) begin
    if (acc_in && kind == KIND_RANGE) rt_mem[in_tdata[15:8]] <= in_tdata[31:16];
    rt_q_r <= rt_mem[dif];
    rt_v_r <= rt_vld_r[dif];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_vld_r <= '0;
      for (int i = 0; i < SP_DEPTH; i++) sp_tab_r[i] <= '0;
    end else if (acc_in) begin
      if (kind == KIND_RANGE) rt_vld_r[in_tdata[15:8]] <= 1'b1;
      if (kind == KIND_SPATIAL && in_tdata[15:8] < SP_DEPTH) begin
        sp_tab_r[SPW'(in_tdata[15:8])] <= in_tdata[31:16];
      end
    end
  end

  // Weight pipeline: pixel fetch, table reads, weight product, accumulate.
  logic [31:0] wprod;
  assign wprod = p2_s_r * (rt_v_r ? rt_q_r : 16'd0);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= (state_r == S_TAPS);
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
    p1_in_r   <= tap_in;
    p1_sidx_r <= SPW'(sq);
    p2_in_r   <= p1_in_r;
    p2_n_r    <= ls_q_r;
    p2_s_r    <= sp_tab_r[p1_sidx_r];
    // Taps outside the image may fetch stale or unwritten entries.
    p3_n_r    <= p2_in_r ? p2_n_r : 8'd0;
    p3_w_r    <= p2_in_r ? wprod[31:16] : 16'd0;
    if (state_r == S_CHECK) begin
      f_acc_r <= '0;
      k_acc_r <= '0;
    end else if (p3_vld_r) begin
      f_acc_r <= f_acc_r + ACC_W'(p3_n_r * p3_w_r);
      k_acc_r <= k_acc_r + DEN_W'(p3_w_r);
    end
  end

  // Division chain, one quotient bit per cell.
  logic pipe_empty;
  assign pipe_empty = !p1_vld_r && !p2_vld_r && !p3_vld_r;
  always_comb begin
    dv[0].vld = (state_r == S_DRAIN) && pipe_empty;
    dv[0].rem = f_acc_r;
    dv[0].den = k_acc_r;
    dv[0].quo = '0;
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    bfg_div_cell #(.BIT(QUO_W - 1 - g)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (dv[g]),
      .dout (dv[g+1])
    );
  end

  // Control and frame bookkeeping.
  logic em_last;
  logic out_free;
  logic cfg_hit;
  logic out_load;
  assign em_last  = (em_row_r == eff_h - RW'(1)) && (em_col_r == eff_w - CW'(1));
  assign out_free = !out_vld_r || out_tready;
  assign cfg_hit  = cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
                               cfg_index == REG_HEIGHT);
  assign out_load = !cfg_hit && (state_r == S_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      radius_r  <= 2'd1;
      width_r   <= 11'd640;
      height_r  <= 13'd480;
      in_row_r  <= '0;
      in_col_r  <= '0;
      in_slot_r <= '0;
      em_row_r  <= '0;
      em_col_r  <= '0;
      em_slot_r <= '0;
      in_done_r <= 1'b0;
      ti_r      <= '0;
      tj_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_tready && !out_load) out_vld_r <= 1'b0;
      if (cfg_hit) begin
        case (cfg_index)
          REG_RADIUS: radius_r <= cfg_wdata[1:0];
          REG_WIDTH:  width_r  <= cfg_wdata[10:0];
          default:    height_r <= cfg_wdata;
        endcase
        in_row_r  <= '0;
        in_col_r  <= '0;
        in_slot_r <= '0;
        em_row_r  <= '0;
        em_col_r  <= '0;
        em_slot_r <= '0;
        in_done_r <= 1'b0;
        state_r   <= S_IDLE;
      end else begin
        case (state_r)
          S_IDLE: begin
            if (acc_in) begin
              if (pix_take) begin
                if (in_col_r + CW'(1) >= eff_w) begin
                  in_col_r  <= '0;
                  in_row_r  <= in_row_r + RW'(1);
                  in_slot_r <= (in_slot_r == SW'(ROWS - 1)) ? '0 : in_slot_r + SW'(1);
                  if (in_row_r + RW'(1) >= eff_h) in_done_r <= 1'b1;
                end else begin
                  in_col_r <= in_col_r + CW'(1);
                end
              end
              if (kind == KIND_PIXEL || kind == KIND_DRAIN) state_r <= S_CHECK;
            end
          end
          S_CHECK: begin
            state_r <= ready_c ? S_CENTRE : S_IDLE;
            ti_r    <= '0;
            tj_r    <= '0;
          end
          S_CENTRE: state_r <= S_CWAIT;
          S_CWAIT: begin
            centre_r <= ls_q_r;
            state_r  <= S_TAPS;
          end
          S_TAPS: begin
            if (tap_last) begin
              state_r <= S_DRAIN;
            end else if (tj_r == two_r) begin
              tj_r <= '0;
              ti_r <= ti_r + TW'(1);
            end else begin
              tj_r <= tj_r + TW'(1);
            end
          end
          S_DRAIN: begin
            if (pipe_empty) state_r <= S_DIV;
          end
          S_DIV: begin
            if (dv[QUO_W].vld) begin
              res_r   <= (dv[QUO_W].den == '0) ? centre_r : dv[QUO_W].quo;
              state_r <= S_OUT;
            end
          end
          default: begin
            if (out_free) begin
              out_vld_r  <= 1'b1;
              out_last_r <= em_last;
              out_data_r <= {2'b00, 10'(em_col_r), 12'(em_row_r), res_r};
              state_r    <= S_IDLE;
              if (em_last) begin
                in_row_r  <= '0;
                in_col_r  <= '0;
                in_slot_r <= '0;
                em_row_r  <= '0;
                em_col_r  <= '0;
                em_slot_r <= '0;
                in_done_r <= 1'b0;
              end else if (em_col_r + CW'(1) >= eff_w) begin
                em_col_r  <= '0;
                em_row_r  <= em_row_r + RW'(1);
                em_slot_r <= (em_slot_r == SW'(ROWS - 1)) ? '0 : em_slot_r + SW'(1);
              end else begin
                em_col_r <= em_col_r + CW'(1);
              end
            end
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `BFG_ASSERT_IMP(a_div_in_div_state, dv[QUO_W].vld, state_r == S_DIV)
  `BFG_ASSERT_IMP(a_pipe_idle_outside, (state_r == S_IDLE || state_r == S_OUT), pipe_empty)
  `BFG_ASSERT_NXT(a_drain_to_div, (state_r == S_DRAIN && pipe_empty && !cfg_we), state_r == S_DIV)
  `BFG_ASSERT_IMP(a_done_at_row_start, in_done_r, in_col_r == '0)

endmodule

>>> hw/rtl/bfg_div_cell.sv
module bfg_div_cell import bfg_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  div_t din,
  output div_t dout
);

  logic [ACC_W-1:0] shifted;
  logic             take;

  assign shifted = ACC_W'(din.den) << BIT;
  // The quotient never exceeds the largest pixel, so the shifted divisor
  // cannot overflow a remainder that still needs this bit.
  assign take    = (din.rem >= shifted) && ((shifted >> BIT) == ACC_W'(din.den));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.den <= din.den;
    dout.rem <= take ? din.rem - shifted : din.rem;
    dout.quo <= take ? (din.quo | (QUO_W'(1) << BIT)) : din.quo;
  end

endmodule

>>> verif/bilateral_filter_gray_core_test.sv
`timescale 1ns / 1ps
module bilateral_filter_gray_core_test;
  import bfg_pkg::*;

  localparam int MR = 3;
  localparam int MW = 1024;
  localparam int MH = 4096;
  localparam int ROWS = 2 * MR + 2;
  localparam int SP_DEPTH = 2 * MR * MR + 1;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] weight;
    logic [7:0]  table_index;
    logic [7:0]  pixel;
  } pix_item_t;

  typedef struct packed {
    logic        last_of_frame;
    logic [9:0]  col;
    logic [11:0] row;
    logic [7:0]  value;
  } filt_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // pixel[7:0], table_index[15:8], weight[31:16]
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // filtered_pixel[7:0], out_row[19:8], out_col[29:20]
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_wdata;

  bilateral_filter_gray_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state.
  logic [7:0]  frame_lines [ROWS * MW];
  logic [15:0] range_lut [256];
  logic [15:0] spatial_lut [SP_DEPTH];
  int unsigned next_in_row, next_in_col, next_out_row, next_out_col;
  bit          frame_received;
  int unsigned win_radius, img_w, img_h;

  pix_item_t   pending_items [$];
  filt_res_t   expected_pixels [$];
  int          error_count;
  int          items_added;
  bit          lane_quiet;
  bit          hold_off;
  bit          stimulus_done;
  longint      cycle_count;

  // Handshake flags captured at the rising edge.
  logic in_tready_s;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int unsigned eff_r();
    return win_radius > MR ? MR : win_radius;
  endfunction
  function automatic int unsigned eff_w();
    if (img_w == 0) return 1;
    return img_w > MW ? MW : img_w;
  endfunction
  function automatic int unsigned eff_h();
    if (img_h == 0) return 1;
    return img_h > MH ? MH : img_h;
  endfunction

  function automatic logic [7:0] line_px(int unsigned r, int unsigned c);
    return frame_lines[(r % ROWS) * MW + (c % MW)];
  endfunction

  function automatic void restart_frame();
    next_in_row = 0; next_in_col = 0; next_out_row = 0; next_out_col = 0;
    frame_received = 0;
  endfunction

  function automatic logic [7:0] smooth_at(int unsigned er, int unsigned ec);
    logic [7:0]  ctr, nb;
    longint unsigned num, den, s, rw, w;
    int r, c, d, rad;
    ctr = line_px(er, ec);
    num = 0; den = 0;
    rad = eff_r();
    for (int dr = -rad; dr <= rad; dr++) begin
      r = int'(er) + dr;
      if (r < 0 || r >= int'(eff_h())) continue;
      for (int dc = -rad; dc <= rad; dc++) begin
        c = int'(ec) + dc;
        if (c < 0 || c >= int'(eff_w())) continue;
        nb = line_px(r, c);
        d = nb > ctr ? nb - ctr : ctr - nb;
        s = spatial_lut[(dr * dr + dc * dc) % SP_DEPTH];
        rw = range_lut[d];
        w = (s * rw) >> 16;
        num += nb * w;
        den += w;
      end
    end
    if (den == 0) return ctr;
    num = num / den;
    return num > 255 ? 8'd255 : num[7:0];
  endfunction

  function automatic void predict_item(pix_item_t it);
    int unsigned nr, nc, W, H;
    longint unsigned got, need;
    bit fin;
    filt_res_t res;
    W = eff_w(); H = eff_h();
    if (it.kind == KIND_RANGE) begin
      range_lut[it.table_index] = it.weight;
      return;
    end
    if (it.kind == KIND_SPATIAL) begin
      if (it.table_index < SP_DEPTH) spatial_lut[it.table_index] = it.weight;
      return;
    end
    if (it.kind == KIND_PIXEL && !frame_received) begin
      frame_lines[(next_in_row % ROWS) * MW + (next_in_col % MW)] = it.pixel;
      next_in_col++;
      if (next_in_col >= W) begin
        next_in_col = 0;
        next_in_row++;
        if (next_in_row >= H) frame_received = 1;
      end
    end
    nr = next_out_row + eff_r(); if (nr > H - 1) nr = H - 1;
    nc = next_out_col + eff_r(); if (nc > W - 1) nc = W - 1;
    got = longint'(next_in_row) * W + next_in_col;
    need = longint'(nr) * W + nc;
    if (!(frame_received || got > need)) return;
    fin = (next_out_row == H - 1) && (next_out_col == W - 1);
    res.value = smooth_at(next_out_row, next_out_col);
    res.row = next_out_row[11:0];
    res.col = next_out_col[9:0];
    res.last_of_frame = fin;
    expected_pixels.push_back(res);
    if (fin) restart_frame();
    else begin
      next_out_col++;
      if (next_out_col >= W) begin
        next_out_col = 0;
        next_out_row++;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Driver: the item on the bus is predicted when its transfer completes.
  // An offered item stays on the bus until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready_s) begin
        predict_item(pix_item_t'({in_tuser, in_tdata}));
        void'(pending_items.pop_front());
      end
      if (pending_items.size() != 0 && ((in_tvalid && !in_tready_s) || lane_quiet ||
                                        $urandom_range(99) >= 11)) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_items[0][31:0];
        in_tuser <= pending_items[0].kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) in_tready_s <= in_tready;

  always @(negedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= lane_quiet || $urandom_range(99) >= 11;
  end

  // Monitor.
  always @(posedge clk) begin
    filt_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata[29:0]};
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result row", got.row, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (got.value !== want.value) report_mismatch("pixel", got.value, want.value);
        if (got.row !== want.row) report_mismatch("row", got.row, want.row);
        if (got.col !== want.col) report_mismatch("col", got.col, want.col);
        if (got.last_of_frame !== want.last_of_frame)
          report_mismatch("last", got.last_of_frame, want.last_of_frame);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (2 * 49 + 64) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val[12:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RADIUS) win_radius = val & 3;
    else if (idx == REG_WIDTH) img_w = val & 'h7ff;
    else img_h = val & 'h1fff;
    restart_frame();
  endtask

  function automatic void add_item(logic [1:0] k, int unsigned px, int unsigned ix,
                                   int unsigned wt);
    pix_item_t it;
    it.kind = k; it.pixel = px[7:0]; it.table_index = ix[7:0]; it.weight = wt[15:0];
    pending_items.push_back(it);
    items_added++;
  endfunction

  function automatic void add_frame(int unsigned n_px, int unsigned drains);
    for (int i = 0; i < n_px; i++) begin
      if ($urandom_range(99) < 3) add_item(KIND_RANGE, 0, $urandom, $urandom);
      else if ($urandom_range(99) < 2) add_item(KIND_SPATIAL, 0, $urandom_range(25), $urandom);
      add_item(KIND_PIXEL, $urandom_range(7) == 0 ? 255 * $urandom_range(1) : $urandom,
               $urandom, $urandom);
    end
    for (int i = 0; i < drains; i++) add_item(KIND_DRAIN, $urandom, $urandom, $urandom);
  endfunction

  task automatic run_frame(int r, int w, int h, int n_px, int drains);
    wait_idle();
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    add_frame(n_px, drains);
  endtask

  initial begin
    int unsigned sent;
    int w, h;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    out_tready = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    error_count = 0; cycle_count = 0; lane_quiet = 0; hold_off = 0;
    stimulus_done = 0; items_added = 0;
    for (int i = 0; i < ROWS * MW; i++) frame_lines[i] = '0;
    for (int i = 0; i < 256; i++) range_lut[i] = '0;
    for (int i = 0; i < SP_DEPTH; i++) spatial_lut[i] = '0;
    win_radius = 1; img_w = 640; img_h = 480;
    restart_frame();
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Zero tables: every result is the centre pixel.
    run_frame(1, 3, 2, 6, 4);
    // Table loads, extremes of fields, bad spatial index.
    for (int i = 0; i < SP_DEPTH; i++) add_item(KIND_SPATIAL, 0, i, 16'hffff - i * 1000);
    add_item(KIND_SPATIAL, 0, 255, 16'h1234);
    add_item(KIND_SPATIAL, 0, SP_DEPTH, 16'h0);
    for (int i = 0; i < 256; i++) add_item(KIND_RANGE, 0, i, i < 40 ? 16'hffff - i * 1500 : 16'h0);
    // Radius 0, single pixel frame, then extra pixels after a complete frame.
    run_frame(0, 1, 1, 1, 0);
    add_item(KIND_PIXEL, 0, 0, 0);
    run_frame(3, 4, 3, 12, 6);
    add_frame(3, 5);
    // Zero width and height act as one; oversize values saturate.
    run_frame(2, 0, 0, 1, 1);
    run_frame(3, 2047, 1, 20, 4);
    wait_idle();
    write_reg(REG_RADIUS, 2); write_reg(REG_WIDTH, 1024); write_reg(REG_HEIGHT, 8191);
    add_frame(30, 0);
    // Write mid-frame drops pending output.
    wait_idle();
    write_reg(REG_HEIGHT, 4096);

    sent = 0;
    while (items_added < 1250) begin
      w = $urandom_range(1, 12); h = $urandom_range(1, 8);
      if ($urandom_range(9) == 0) w = $urandom_range(60, 140);
      lane_quiet = (sent >= 150 && sent < 350);
      run_frame($urandom_range(3), w, h, w * h, $urandom_range(2, 3 * w + 4));
      if (sent < 80) begin
        // Long receiver hold-off with the sender still busy.
        fork
          begin
            hold_off = 1;
            repeat (600) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      sent += w * h;
    end
    wait_idle();
    lane_quiet = 0;
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
